>>> rtl/core/led_dual_channel_pattern_sequencer_macros.svh
// Assertion macros shared by the LED pattern sequencer RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef LED_DUAL_CHANNEL_PATTERN_SEQUENCER_MACROS_SVH
`define LED_DUAL_CHANNEL_PATTERN_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LDCPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LDCPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ldcps_pkg.sv
// Shared types, constants and helper functions for the LED pattern sequencer.
// No dependencies.
`default_nettype none

package ldcps_pkg;

  localparam int TABLE_ENTRIES = 14;

  // configuration register indexes
  localparam logic [2:0] CFG_SW_THR   = 3'd0;
  localparam logic [2:0] CFG_DK_THR   = 3'd1;
  localparam logic [2:0] CFG_ON       = 3'd2;
  localparam logic [2:0] CFG_OFF      = 3'd3;
  localparam logic [2:0] CFG_START    = 3'd4;
  localparam logic [2:0] CFG_MIN_DUTY = 3'd5;

  // patterns
  localparam logic [2:0] PAT_OFF  = 3'd0;
  localparam logic [2:0] PAT_MIN  = 3'd1;
  localparam logic [2:0] PAT_HALF = 3'd2;
  localparam logic [2:0] PAT_MAX  = 3'd3;
  localparam logic [2:0] PAT_RAMP = 3'd4;

  // channel codes held in the mode ROM nibbles
  localparam logic [3:0] CH_OFF_TO_MAX = 4'd1;
  localparam logic [3:0] CH_MIN_TO_MAX = 4'd2;
  localparam logic [3:0] CH_MAX_TO_MIN = 4'd3;
  localparam logic [3:0] CH_MAX_TO_OFF = 4'd4;
  localparam logic [3:0] CH_MAX        = 4'd5;
  localparam logic [3:0] CH_MIN        = 4'd6;

  localparam logic [8:0] FULL_DUTY = 9'd500;
  localparam logic [8:0] HALF_DUTY = 9'd250;

  localparam logic [5:0]  SW_THR_RST   = 6'd30;
  localparam logic [6:0]  DK_THR_RST   = 7'd100;
  localparam logic [12:0] ON_RST       = 13'd1098;
  localparam logic [12:0] OFF_RST      = 13'd5494;
  localparam logic [2:0]  START_RST    = PAT_OFF;
  localparam logic [7:0]  MIN_DUTY_RST = 8'd50;

  typedef struct packed {
    logic [5:0]  sw_thr;
    logic [6:0]  dk_thr;
    logic [12:0] on_ticks;
    logic [12:0] off_ticks;
  } cfg_t;

  typedef struct packed {
    logic       restart;
    logic       lights_on;
    logic [2:0] pattern;
    logic       changed;
  } ctrl_t;

  function automatic logic [2:0] valid_pattern(input logic [2:0] p);
    return (p > PAT_RAMP) ? PAT_OFF : p;
  endfunction

  function automatic logic [5:0] clamp_sw(input logic [5:0] t);
    logic [5:0] r;
    r = t;
    if (t == 6'd0) r = 6'd1;
    else if (t > 6'd62) r = 6'd62;
    return r;
  endfunction

  function automatic logic [6:0] clamp_dk(input logic [6:0] t);
    logic [6:0] r;
    r = t;
    if (t == 7'd0) r = 7'd1;
    else if (t > 7'd126) r = 7'd126;
    return r;
  endfunction

  // red in low nibble, green in high nibble; 7 means off
  function automatic logic [7:0] mode_rom(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd0:    m = 8'h11;
      4'd1:    m = 8'h33;
      4'd2:    m = 8'h22;
      4'd3:    m = 8'h33;
      4'd4:    m = 8'h22;
      4'd5:    m = 8'h35;
      4'd6:    m = 8'h23;
      4'd7:    m = 8'h32;
      4'd8:    m = 8'h23;
      4'd9:    m = 8'h42;
      4'd10:   m = 8'h75;
      4'd11:   m = 8'h14;
      4'd12:   m = 8'h57;
      4'd13:   m = 8'h51;
      default: m = 8'h77;
    endcase
    return m;
  endfunction

  function automatic logic [8:0] channel_duty(input logic [3:0] code, input logic [8:0] lvl,
                                              input logic [7:0] mn);
    logic [8:0] mn9;
    logic [8:0] d;
    mn9 = {1'b0, mn};
    case (code)
      CH_OFF_TO_MAX: d = lvl;
      CH_MIN_TO_MAX: d = (lvl < mn9) ? mn9 : lvl;
      CH_MAX_TO_MIN: d = (lvl > (FULL_DUTY - mn9)) ? mn9 : (FULL_DUTY - lvl);
      CH_MAX_TO_OFF: d = FULL_DUTY - lvl;
      CH_MAX:        d = FULL_DUTY;
      CH_MIN:        d = mn9;
      default:       d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ldcps_ctrl.sv
// Tick control: button and dark debounce, pattern select, time-of-day counter.
// Depends on ldcps_pkg.
`default_nettype none

module ldcps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic               btn,
  input  wire logic               dark,
  input  wire logic               dtick,
  input  wire ldcps_pkg::cfg_t    cfg,
  input  wire logic               load_pat,
  input  wire logic [2:0]         load_val,
  output ldcps_pkg::ctrl_t        ctrl
);

  logic [5:0]  btn_cnt_r, btn_cnt_nxt;
  logic [6:0]  dk_cnt_r, dk_cnt_nxt;
  logic [2:0]  pat_r, pat_nxt;
  logic [13:0] day_r, day_nxt;

  logic [5:0]  sw_thr;
  logic [6:0]  dk_thr;
  logic [13:0] day_inc, day_a;
  logic        day_wrap, press, dark_evt;

  always_comb begin
    sw_thr  = ldcps_pkg::clamp_sw(cfg.sw_thr);
    dk_thr  = ldcps_pkg::clamp_dk(cfg.dk_thr);

    day_inc  = day_r + 14'd1;
    day_wrap = ({1'b0, day_inc} + 15'd2) > ({2'b0, cfg.on_ticks} + {2'b0, cfg.off_ticks});
    day_a    = dtick ? (day_wrap ? 14'd0 : day_inc) : day_r;

    // saturating counters stop at threshold + 1
    if (btn) btn_cnt_nxt = (btn_cnt_r <= sw_thr) ? btn_cnt_r + 6'd1 : btn_cnt_r;
    else     btn_cnt_nxt = 6'd0;
    press = (btn_cnt_nxt == sw_thr);

    if (dark) dk_cnt_nxt = (dk_cnt_r <= dk_thr) ? dk_cnt_r + 7'd1 : dk_cnt_r;
    else      dk_cnt_nxt = 7'd0;
    dark_evt = (dk_cnt_nxt == dk_thr);

    pat_nxt = pat_r;
    if (press) pat_nxt = (pat_r >= ldcps_pkg::PAT_RAMP) ? ldcps_pkg::PAT_OFF : pat_r + 3'd1;

    day_nxt = (press || dark_evt) ? 14'd0 : day_a;

    ctrl.restart   = press || dark_evt;
    ctrl.lights_on = day_nxt < {1'b0, cfg.on_ticks};
    ctrl.pattern   = pat_nxt;
    ctrl.changed   = press;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_cnt_r <= '0;
      dk_cnt_r  <= '0;
      day_r     <= '0;
      pat_r     <= ldcps_pkg::valid_pattern(ldcps_pkg::START_RST);
    end else begin
      if (step) begin
        btn_cnt_r <= btn_cnt_nxt;
        dk_cnt_r  <= dk_cnt_nxt;
        day_r     <= day_nxt;
      end
      if (load_pat) begin
        pat_r <= ldcps_pkg::valid_pattern(load_val);
      end else if (step) begin
        pat_r <= pat_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ldcps_ramp.sv
// Ramp generator with mode ROM and per-pattern duty selection.
// Depends on ldcps_pkg.
`default_nettype none

module ldcps_ramp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire ldcps_pkg::ctrl_t ctrl,
  input  wire logic [7:0]       min_duty,
  output logic [8:0]            red,
  output logic [8:0]            green
);

  logic [8:0] lvl_r, lvl_nxt;
  logic [3:0] ent_r, ent_nxt;

  logic [8:0] lvl0, lvl1;
  logic [3:0] ent0;
  logic [4:0] ent_inc;
  logic [1:0] inc;
  logic [7:0] mode;
  logic       active;

  always_comb begin
    lvl0   = ctrl.restart ? 9'd0 : lvl_r;
    ent0   = ctrl.restart ? 4'd0 : ent_r;
    active = ctrl.lights_on && (ctrl.pattern == ldcps_pkg::PAT_RAMP);

    // slower near both ends of the ramp
    if (lvl0 > 9'd400 || lvl0 < 9'd100)      inc = 2'd1;
    else if (lvl0 > 9'd300 || lvl0 < 9'd200) inc = 2'd2;
    else                                     inc = 2'd3;
    lvl1    = lvl0 + {7'd0, inc};
    ent_inc = {1'b0, ent0} + 5'd1;

    lvl_nxt = lvl0;
    ent_nxt = ent0;
    if (active) begin
      if (lvl1 >= ldcps_pkg::FULL_DUTY) begin
        lvl_nxt = 9'd0;
        ent_nxt = (ent_inc >= 5'(ldcps_pkg::TABLE_ENTRIES)) ? 4'd1 : ent_inc[3:0];
      end else begin
        lvl_nxt = lvl1;
      end
    end

    mode  = ldcps_pkg::mode_rom(ent_nxt);
    red   = 9'd0;
    green = 9'd0;
    if (ctrl.lights_on) begin
      case (ctrl.pattern)
        ldcps_pkg::PAT_MIN: begin
          red   = {1'b0, min_duty};
          green = {1'b0, min_duty};
        end
        ldcps_pkg::PAT_HALF: begin
          red   = ldcps_pkg::HALF_DUTY;
          green = ldcps_pkg::HALF_DUTY;
        end
        ldcps_pkg::PAT_MAX: begin
          red   = ldcps_pkg::FULL_DUTY;
          green = ldcps_pkg::FULL_DUTY;
        end
        ldcps_pkg::PAT_RAMP: begin
          red   = ldcps_pkg::channel_duty(mode[3:0], lvl_nxt, min_duty);
          green = ldcps_pkg::channel_duty(mode[7:4], lvl_nxt, min_duty);
        end
        default: begin
          red   = 9'd0;
          green = 9'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0;
      ent_r <= '0;
    end else if (step) begin
      lvl_r <= lvl_nxt;
      ent_r <= ent_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/led_dual_channel_pattern_sequencer.sv
// Top level of the dual-channel LED pattern sequencer: input register,
// configuration registers, output register. Uses ldcps_pkg, ldcps_ctrl, ldcps_ramp.
//
// Usage: each input beat (in_valid/in_ready) is one 25 ms control tick with
// button, dark-sensor and day-timer levels. Each tick yields exactly one
// output beat (out_valid/out_ready) with red/green duty, the current pattern
// and a flag set on the tick a debounced press advanced the pattern.
// Configuration goes through cfg_valid/cfg_ready (always ready) with
// cfg_index selecting a register; write only while no tick is in flight.
// Writing start_pattern reloads the pattern at once.
// A beat passes through the input register and then the output register.
// Throughput: one tick per cycle while out_ready stays high; the state update
// is a single registered pass from the input register to the output register.
// Reset (rst_n low, synchronous) clears all counters, loads the default
// configuration and pattern 0, and empties both registers.
// When the receiver stalls, the result holds in the output register and one
// more tick may wait in the input register; after that in_ready drops.
`default_nettype none

`include "led_dual_channel_pattern_sequencer_macros.svh"

module led_dual_channel_pattern_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_button_pressed,
  input  wire logic        in_is_dark,
  input  wire logic        in_day_tick,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [8:0]       out_red_duty,
  output logic [8:0]       out_green_duty,
  output logic [2:0]       out_pattern_now,
  output logic             out_pattern_changed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  ldcps_pkg::cfg_t  cfg_r;
  ldcps_pkg::ctrl_t ctrl;
  logic [7:0]       min_duty_r;

  logic s1_vld_r, s1_btn_r, s1_dark_r, s1_dtick_r;
  logic out_vld_r;
  logic advance, cfg_wr, load_pat;
  logic [8:0] red, green;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign load_pat  = cfg_wr && (cfg_index == ldcps_pkg::CFG_START);

  assign advance  = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || advance;
  assign out_valid = out_vld_r;

  // start_pattern goes straight into the pattern register of u_ctrl
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sw_thr    <= ldcps_pkg::SW_THR_RST;
      cfg_r.dk_thr    <= ldcps_pkg::DK_THR_RST;
      cfg_r.on_ticks  <= ldcps_pkg::ON_RST;
      cfg_r.off_ticks <= ldcps_pkg::OFF_RST;
      min_duty_r      <= ldcps_pkg::MIN_DUTY_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        ldcps_pkg::CFG_SW_THR:   cfg_r.sw_thr    <= cfg_data[5:0];
        ldcps_pkg::CFG_DK_THR:   cfg_r.dk_thr    <= cfg_data[6:0];
        ldcps_pkg::CFG_ON:       cfg_r.on_ticks  <= cfg_data;
        ldcps_pkg::CFG_OFF:      cfg_r.off_ticks <= cfg_data;
        ldcps_pkg::CFG_MIN_DUTY: min_duty_r      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_btn_r   <= in_button_pressed;
      s1_dark_r  <= in_is_dark;
      s1_dtick_r <= in_day_tick;
    end
  end

  ldcps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .btn      (s1_btn_r),
    .dark     (s1_dark_r),
    .dtick    (s1_dtick_r),
    .cfg      (cfg_r),
    .load_pat (load_pat),
    .load_val (cfg_data[2:0]),
    .ctrl     (ctrl)
  );

  ldcps_ramp u_ramp (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .ctrl     (ctrl),
    .min_duty (min_duty_r),
    .red      (red),
    .green    (green)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_red_duty        <= red;
      out_green_duty      <= green;
      out_pattern_now     <= ctrl.pattern;
      out_pattern_changed <= ctrl.changed;
    end
  end

  `LDCPS_ASSERT_NEXT(a_adv_loads_out, advance, out_vld_r, "tick advanced but no output beat")
  `LDCPS_ASSERT_NEXT(a_stall_keeps_s1, s1_vld_r && out_vld_r && !out_ready, s1_vld_r,
                     "pending tick dropped while output stalled")
  `LDCPS_ASSERT_NOW(a_duty_range, out_vld_r,
                    out_red_duty <= ldcps_pkg::FULL_DUTY && out_green_duty <= ldcps_pkg::FULL_DUTY,
                    "duty above full scale")
  `LDCPS_ASSERT_NOW(a_change_restart, advance && ctrl.changed, ctrl.restart,
                    "pattern advance without day restart")
  `LDCPS_ASSERT_NOW(a_start_load, load_pat, cfg_index == ldcps_pkg::CFG_START,
                    "pattern load on wrong register index")

endmodule

`default_nettype wire

>>> tb/led_dual_channel_pattern_sequencer_tb.sv
// Self-checking bench for led_dual_channel_pattern_sequencer: control ticks go in on
// the in_ channel, and every out_ beat is checked against a tick-by-tick duty predictor.
// Depends on ldcps_pkg and the sequencer RTL only.
`default_nettype none

module led_dual_channel_pattern_sequencer_tb;

  localparam int STALL_LIMIT = 2000;

  // mode entries 15 down to 0: red code in the low nibble, green in the high one
  localparam logic [127:0] MODE_TABLE = {
    8'h77, 8'h77, 8'h51, 8'h57, 8'h14, 8'h75, 8'h42, 8'h23,
    8'h32, 8'h23, 8'h35, 8'h22, 8'h33, 8'h22, 8'h33, 8'h11
  };

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [2:0] pat;
    logic       chg;
  } lamp_t;

  class duty_tracker;
    int unsigned sw_thr, dk_thr, on_t, off_t, min_d;
    int unsigned btn_cnt, dark_cnt, day_cnt, level, entry;
    logic [2:0]  pat;
    lamp_t       due[$];
    int          errors, ticks, results, writes, advances;
    bit [15:0]   entries_seen;

    function new();
      sw_thr = ldcps_pkg::SW_THR_RST;
      dk_thr = ldcps_pkg::DK_THR_RST;
      on_t = ldcps_pkg::ON_RST;
      off_t = ldcps_pkg::OFF_RST;
      min_d = ldcps_pkg::MIN_DUTY_RST;
      pat = (ldcps_pkg::START_RST > ldcps_pkg::PAT_RAMP) ? ldcps_pkg::PAT_OFF
                                                         : ldcps_pkg::START_RST;
      btn_cnt = 0;
      dark_cnt = 0;
      day_cnt = 0;
      level = 0;
      entry = 0;
      errors = 0;
      ticks = 0;
      results = 0;
      writes = 0;
      advances = 0;
      entries_seen = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [12:0] data);
      writes++;
      case (idx)
        ldcps_pkg::CFG_SW_THR:   sw_thr = data[5:0];
        ldcps_pkg::CFG_DK_THR:   dk_thr = data[6:0];
        ldcps_pkg::CFG_ON:       on_t = data;
        ldcps_pkg::CFG_OFF:      off_t = data;
        ldcps_pkg::CFG_START:
          pat = (data[2:0] > ldcps_pkg::PAT_RAMP) ? ldcps_pkg::PAT_OFF : data[2:0];
        ldcps_pkg::CFG_MIN_DUTY: min_d = data[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned level_duty(logic [3:0] code);
      int unsigned d;
      case (code)
        ldcps_pkg::CH_OFF_TO_MAX: d = level;
        ldcps_pkg::CH_MIN_TO_MAX: d = (level < min_d) ? min_d : level;
        ldcps_pkg::CH_MAX_TO_MIN:
          d = (level > ldcps_pkg::FULL_DUTY - min_d) ? min_d : ldcps_pkg::FULL_DUTY - level;
        ldcps_pkg::CH_MAX_TO_OFF: d = ldcps_pkg::FULL_DUTY - level;
        ldcps_pkg::CH_MAX:        d = ldcps_pkg::FULL_DUTY;
        ldcps_pkg::CH_MIN:        d = min_d;
        default:                  d = 0;
      endcase
      return d;
    endfunction

    // one tick: day counter, both debouncers, then the duty for the current pattern
    function void take_tick(bit btn, bit dark, bit dtick);
      int unsigned sw_eff, dk_eff, red, green, step;
      bit          moved;
      logic [7:0]  modes;
      lamp_t       want;
      sw_eff = (sw_thr == 0) ? 1 : (sw_thr > 62) ? 62 : sw_thr;
      dk_eff = (dk_thr == 0) ? 1 : (dk_thr > 126) ? 126 : dk_thr;
      red = 0;
      green = 0;
      moved = 1'b0;
      ticks++;
      if (dtick) begin
        day_cnt = (day_cnt + 1) & 32'h3FFF;
        if (day_cnt + 2 > on_t + off_t) day_cnt = 0;
      end
      if (btn) begin
        if (btn_cnt <= sw_eff) btn_cnt++;
      end else begin
        btn_cnt = 0;
      end
      if (btn_cnt == sw_eff) begin
        pat = (pat >= ldcps_pkg::PAT_RAMP) ? ldcps_pkg::PAT_OFF : pat + 3'd1;
        moved = 1'b1;
        advances++;
        day_cnt = 0;
        level = 0;
        entry = 0;
      end
      if (dark) begin
        if (dark_cnt <= dk_eff) dark_cnt++;
      end else begin
        dark_cnt = 0;
      end
      if (dark_cnt == dk_eff) begin
        day_cnt = 0;
        level = 0;
        entry = 0;
      end
      if (day_cnt < on_t) begin
        case (pat)
          ldcps_pkg::PAT_MIN: begin
            red = min_d;
            green = min_d;
          end
          ldcps_pkg::PAT_HALF: begin
            red = ldcps_pkg::HALF_DUTY;
            green = ldcps_pkg::HALF_DUTY;
          end
          ldcps_pkg::PAT_MAX: begin
            red = ldcps_pkg::FULL_DUTY;
            green = ldcps_pkg::FULL_DUTY;
          end
          ldcps_pkg::PAT_RAMP: begin
            // coarse steps through the middle of the ramp, fine near both ends
            if (level > 400 || level < 100) step = 1;
            else if (level > 300 || level < 200) step = 2;
            else step = 3;
            level += step;
            if (level >= ldcps_pkg::FULL_DUTY) begin
              level = 0;
              entry++;
              if (entry >= ldcps_pkg::TABLE_ENTRIES) entry = 1;
            end
            modes = MODE_TABLE[entry * 8 +: 8];
            entries_seen[entry] = 1'b1;
            red = level_duty(modes[3:0]);
            green = level_duty(modes[7:4]);
          end
          default: ;
        endcase
      end
      want.red = red[8:0];
      want.green = green[8:0];
      want.pat = pat;
      want.chg = moved;
      due.push_back(want);
    endfunction

    function void match_duty(lamp_t got);
      lamp_t want;
      results++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: result %0d arrived with nothing pending: r%0d g%0d p%0d c%0d",
                   results, got.red, got.green, got.pat, got.chg);
        return;
      end
      want = due.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.pat !== want.pat ||
          got.chg !== want.chg) begin
        errors++;
        if (errors <= 10)
          $display("tb: result %0d: exp r%0d g%0d p%0d c%0d, got r%0d g%0d p%0d c%0d",
                   results, want.red, want.green, want.pat, want.chg,
                   got.red, got.green, got.pat, got.chg);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_button_pressed = 1'b0;
  logic        in_is_dark = 1'b0;
  logic        in_day_tick = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [8:0]  out_red_duty;
  logic [8:0]  out_green_duty;
  logic [2:0]  out_pattern_now;
  logic        out_pattern_changed;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = ldcps_pkg::CFG_SW_THR;
  logic [12:0] cfg_data = '0;

  duty_tracker lamps;
  lamp_t       got_lamp;
  bit          idle_on = 1'b1;
  int          ticks_sent = 0;
  int          stall_cycles = 0;

  led_dual_channel_pattern_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_button_pressed   (in_button_pressed),
    .in_is_dark          (in_is_dark),
    .in_day_tick         (in_day_tick),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_red_duty        (out_red_duty),
    .out_green_duty      (out_green_duty),
    .out_pattern_now     (out_pattern_now),
    .out_pattern_changed (out_pattern_changed),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // all handshakes are sampled with pre-edge values; stimulus moves by NBA
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) lamps.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) lamps.take_tick(in_button_pressed, in_is_dark, in_day_tick);
      if (out_valid && out_ready) begin
        got_lamp.red = out_red_duty;
        got_lamp.green = out_green_duty;
        got_lamp.pat = out_pattern_now;
        got_lamp.chg = out_pattern_changed;
        lamps.match_duty(got_lamp);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: no beat moved for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off so the block backs up
  initial begin : result_sink
    int  taken;
    bit  held;
    taken = 0;
    held = 1'b0;
    forever begin
      if (!held && taken >= 80) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) taken++;
    end
  end

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic send_tick(input bit btn, input bit dark, input bit dtick);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_button_pressed <= btn;
    in_is_dark <= dark;
    in_day_tick <= dtick;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // junk above the width of the threshold, start and floor registers must be dropped by the block
  task automatic configure(input int sw, input int dk, input int on_t, input int off_t,
                           input int start, input int mn);
    cfg_write(ldcps_pkg::CFG_SW_THR, {7'($urandom), 6'(sw)});
    cfg_write(ldcps_pkg::CFG_DK_THR, {6'($urandom), 7'(dk)});
    cfg_write(ldcps_pkg::CFG_ON, 13'(on_t));
    cfg_write(ldcps_pkg::CFG_OFF, 13'(off_t));
    cfg_write(ldcps_pkg::CFG_START, {10'($urandom), 3'(start)});
    cfg_write(ldcps_pkg::CFG_MIN_DUTY, {5'($urandom), 8'(mn)});
    cfg_valid <= 1'b0;
  endtask

  // drop in_valid and let the handshake be sampled so the last accepted tick is already in the pending queue
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lamps.due.size() != 0) @(posedge clk);
  endtask

  // mostly held presses and dark spells around the debounce thresholds, some cut short,
  // the rest random noise
  task automatic play_mix(input int n, input int sw_eff, input int dk_eff, input int tick_pct);
    int goal, kind, len;
    bit with_dark;
    goal = ticks_sent + n;
    while (ticks_sent < goal) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = (kind < 3) ? $urandom_range(sw_eff, sw_eff + 2) : $urandom_range(1, sw_eff + 2);
        with_dark = ($urandom_range(0, 3) == 0);
        repeat (len) send_tick(1'b1, with_dark, roll(tick_pct));
        repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0, roll(tick_pct));
      end else if (kind < 8) begin
        len = (kind < 7) ? $urandom_range(dk_eff, dk_eff + 2) : $urandom_range(1, dk_eff + 2);
        repeat (len) send_tick(1'b0, 1'b1, roll(tick_pct));
        repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b0, roll(tick_pct));
      end else begin
        repeat ($urandom_range(1, 6))
          send_tick($urandom_range(0, 1), $urandom_range(0, 1), roll(tick_pct));
      end
    end
  endtask

  // pattern 4 left running so the ramp climbs and steps to the next mode entry
  task automatic soak_ramp(input int n);
    repeat (n) send_tick($urandom_range(0, 31) == 0, $urandom_range(0, 31) == 0, roll(12));
  endtask

  initial begin : stimulus
    int i, k, sw, dk;
    lamps = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: three ticks are far below either debounce threshold
    repeat (3) send_tick(1'b1, 1'b1, 1'b1);
    wait_idle();

    // zero thresholds act as one, invalid start pattern, one-tick lit window
    configure(0, 0, 1, 2, 7, 0);
    for (i = 0; i < 16; i++) send_tick(i[0], i[3], i[1]);
    wait_idle();

    // top thresholds clamp to 62 / 126, longest day, brightest floor
    configure(63, 127, 8191, 8191, 3, 255);
    play_mix(120, 62, 126, 50);
    wait_idle();

    configure(5, 8, 8191, 100, 4, 250);
    soak_ramp(350);
    wait_idle();
    configure(5, 8, 8191, 100, 4, 0);
    soak_ramp(60);
    wait_idle();
    configure(5, 8, 8191, 100, 4, $urandom_range(0, 255));
    soak_ramp(60);
    wait_idle();

    for (k = 0; k < 5; k++) begin
      sw = $urandom_range(1, 6);
      dk = $urandom_range(1, 8);
      configure(sw, dk, (k == 0) ? 1 : (k == 4) ? 8191 : $urandom_range(1, 12),
                (k == 0) ? 1 : $urandom_range(1, 12), $urandom_range(0, 7),
                $urandom_range(0, 255));
      play_mix(40, sw, dk, 60);
      wait_idle();
    end

    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    configure(2, 3, 40, 10, 4, 60);
    play_mix(80, 2, 3, 30);
    wait_idle();
    repeat (4) @(posedge clk);

    $display("tb: %0d ticks driven, %0d beats checked, %0d register writes, %0d advances",
             lamps.ticks, lamps.results, lamps.writes, lamps.advances);
    $display("tb: ramp lit %0d mode entries; %0d mismatches",
             $countones(lamps.entries_seen), lamps.errors);
    if (lamps.errors == 0 && lamps.due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/ldcps_pkg.sv
rtl/core/ldcps_ctrl.sv
rtl/core/ldcps_ramp.sv
rtl/core/led_dual_channel_pattern_sequencer.sv
tb/led_dual_channel_pattern_sequencer_tb.sv
